// ----- hdl/quadratic_root_chebyshev_top_defines.svh -----
// Assertion macros for the quadratic root Chebyshev block.
// Included by the top level, which holds the block's concurrent assertions.
`ifndef QUADRATIC_ROOT_CHEBYSHEV_TOP_DEFINES_SVH
`define QUADRATIC_ROOT_CHEBYSHEV_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QRC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qrc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define QRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qrc: next-cycle check failed");

`endif

// ----- hdl/qrc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the quadratic root Chebyshev block.
// No dependencies; the interfaces, multiplier, divider, top level and testbench all use it.
package qrc_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int WORD_W            = 32;
  localparam int PROD_W            = 64;
  localparam int DIVISOR_W         = 33;
  localparam int TOL_W             = 17;
  localparam int ITER_W            = 8;
  localparam int CFG_INDEX_W       = 8;
  localparam int CFG_DATA_W        = 32;
  localparam int DIV_STEPS         = PROD_W;

  localparam logic [TOL_W-1:0]  TOL_RESET      = 17'd7;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd64;

  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER  = 8'd1;

  localparam logic signed [PROD_W-1:0] S32_MAX_W = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] S32_MIN_W = -64'sd2147483648;
  localparam logic signed [WORD_W-1:0] S32_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [WORD_W-1:0] S32_MIN   = 32'sh80000000;

  typedef enum logic [1:0] {
    ST_CONVERGED  = 2'd0,
    ST_UNCHANGED  = 2'd1,
    ST_ZERO_DERIV = 2'd2,
    ST_LIMIT      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_AX,
    S_MUL_BX,
    S_MUL_AXX,
    S_CAP_AXX,
    S_SUM,
    S_TEST,
    S_DIV_Q,
    S_MUL_Q2,
    S_CAP_Q2,
    S_MUL_T,
    S_DIV_T_GO,
    S_DIV_T,
    S_STEP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > S32_MAX_W) begin
      r = S32_MAX;
    end else if (v < S32_MIN_W) begin
      r = S32_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/qrc_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for jobs, results and register writes.
// Depends on qrc_pkg for field widths.
interface qrc_job_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [qrc_pkg::WORD_W-1:0]        coefficient_a;
  logic signed [qrc_pkg::WORD_W-1:0]        coefficient_b;
  logic signed [qrc_pkg::WORD_W-1:0]        coefficient_c;
  logic signed [qrc_pkg::WORD_W-1:0]        first_guess;
  modport source (output valid, coefficient_a, coefficient_b, coefficient_c, first_guess,
                  input ready);
  modport sink (input valid, coefficient_a, coefficient_b, coefficient_c, first_guess,
                output ready);
endinterface

interface qrc_result_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [qrc_pkg::WORD_W-1:0]        root;
  logic [qrc_pkg::ITER_W-1:0]               iteration_count;
  logic [1:0]                               status;
  modport source (output valid, root, iteration_count, status, input ready);
  modport sink (input valid, root, iteration_count, status, output ready);
endinterface

interface qrc_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [qrc_pkg::CFG_INDEX_W-1:0]          index;
  logic [qrc_pkg::CFG_DATA_W-1:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/quadratic_root_chebyshev_top.sv -----
`timescale 1ns / 1ps
// Top level of the quadratic root Chebyshev block: sequencer, registers and result stage.
// Depends on qrc_pkg, qrc_ifs, qrc_mul, qrc_div and the assertion macro header.
`include "quadratic_root_chebyshev_top_defines.svh"

// One job finds a root of a*x^2 + b*x + c in signed fixed point by repeated third-order
// Chebyshev steps, starting from the first guess. The block takes one job at a time and
// raises job.ready only between jobs. Every step runs on one registered multiplier and
// one radix-2 divider and makes two divisions. A job ends when an evaluation finds the
// tolerance met, the step limit reached or a zero derivative, or on a step that leaves
// x unchanged. A previous result still waiting to be taken holds the job in its final
// state until it leaves. The finished result sits in an output register, so the next
// job can start while it waits to be taken. Tolerance and the step limit are written
// through the cfg channel, which is always ready.
module quadratic_root_chebyshev_top #(
  parameter int FRACTION_BITS = qrc_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  qrc_job_if.sink      job,
  qrc_result_if.source result,
  qrc_cfg_if.sink      cfg
);
  import qrc_pkg::*;

  state_t state;
  state_t state_next;

  logic [TOL_W-1:0]  tolerance;
  logic [ITER_W-1:0] max_iter;

  logic signed [WORD_W-1:0] a, b, c, x, f2;
  logic signed [WORD_W-1:0] ax, bx, axx, f, f1, q, q2, t;
  logic [ITER_W-1:0]        count;
  status_t                  fin_status;

  logic signed [WORD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [WORD_W-1:0] prod_scaled;

  logic                        div_start;
  logic signed [PROD_W-1:0]    div_dividend;
  logic signed [DIVISOR_W-1:0] div_divisor;
  div_status_t                 div_stat;
  logic signed [WORD_W-1:0]    div_q;

  logic [WORD_W-1:0]        mag;
  logic                     is_conv, is_limit, is_zero;
  logic signed [WORD_W-1:0] xn;
  logic                     fin_load;

  logic                     res_valid;
  logic signed [WORD_W-1:0] res_root;
  logic [ITER_W-1:0]        res_count;
  status_t                  res_status;

  qrc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  qrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      max_iter  <= MAX_ITER_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_TOLERANCE) begin
        tolerance <= cfg.data[TOL_W-1:0];
      end else if (cfg.index == REG_MAX_ITER) begin
        max_iter <= cfg.data[ITER_W-1:0];
      end
    end
  end

  assign prod_scaled = sat32(prod >>> FRACTION_BITS);

  assign mag      = f[WORD_W-1] ? WORD_W'(32'd0 - f) : WORD_W'(f);
  assign is_conv  = mag < WORD_W'(tolerance);
  assign is_limit = count >= max_iter;
  assign is_zero  = f1 == '0;

  assign xn = sat32(PROD_W'(x) - PROD_W'(q) - PROD_W'(t));

  assign fin_load = (state == S_FINISH) && (!res_valid || result.ready);

  always_comb begin
    unique case (state)
      S_MUL_BX: begin
        mul_a = b;
        mul_b = x;
      end
      S_MUL_AXX: begin
        mul_a = ax;
        mul_b = x;
      end
      S_MUL_Q2: begin
        mul_a = q;
        mul_b = q;
      end
      S_MUL_T: begin
        mul_a = q2;
        mul_b = f2;
      end
      default: begin
        mul_a = a;
        mul_b = x;
      end
    endcase
  end

  // The divider serves f/f' scaled up, then the correction term over 2f'.
  always_comb begin
    if (state == S_TEST) begin
      div_dividend = PROD_W'(f) <<< FRACTION_BITS;
      div_divisor  = DIVISOR_W'(f1);
    end else begin
      div_dividend = prod;
      div_divisor  = {f1, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job.ready  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        job.ready = 1'b1;
        if (job.valid) begin
          state_next = S_MUL_AX;
        end
      end
      S_MUL_AX:   state_next = S_MUL_BX;
      S_MUL_BX:   state_next = S_MUL_AXX;
      S_MUL_AXX:  state_next = S_CAP_AXX;
      S_CAP_AXX:  state_next = S_SUM;
      S_SUM:      state_next = S_TEST;
      S_TEST: begin
        if (is_conv || is_limit || is_zero) begin
          state_next = S_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV_Q;
        end
      end
      S_DIV_Q: begin
        if (div_stat.done) begin
          state_next = S_MUL_Q2;
        end
      end
      S_MUL_Q2:   state_next = S_CAP_Q2;
      S_CAP_Q2:   state_next = S_MUL_T;
      S_MUL_T:    state_next = S_DIV_T_GO;
      S_DIV_T_GO: begin
        div_start  = 1'b1;
        state_next = S_DIV_T;
      end
      S_DIV_T: begin
        if (div_stat.done) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        state_next = (xn == x) ? S_FINISH : S_MUL_AX;
      end
      S_FINISH: begin
        if (fin_load) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (job.valid) begin
          a     <= job.coefficient_a;
          b     <= job.coefficient_b;
          c     <= job.coefficient_c;
          x     <= job.first_guess;
          f2    <= sat32(PROD_W'(job.coefficient_a) <<< 1);
          count <= '0;
        end
      end
      S_MUL_BX:  ax  <= prod_scaled;
      S_MUL_AXX: bx  <= prod_scaled;
      S_CAP_AXX: axx <= prod_scaled;
      S_SUM: begin
        f  <= sat32(PROD_W'(axx) + PROD_W'(bx) + PROD_W'(c));
        f1 <= sat32((PROD_W'(ax) <<< 1) + PROD_W'(b));
      end
      S_TEST: begin
        if (is_conv) begin
          fin_status <= ST_CONVERGED;
        end else if (is_limit) begin
          fin_status <= ST_LIMIT;
        end else begin
          fin_status <= ST_ZERO_DERIV;
        end
      end
      S_DIV_Q: begin
        if (div_stat.done) begin
          q <= div_q;
        end
      end
      S_CAP_Q2:  q2 <= prod_scaled;
      S_DIV_T: begin
        if (div_stat.done) begin
          t <= div_q;
        end
      end
      S_STEP: begin
        if (xn == x) begin
          fin_status <= ST_UNCHANGED;
        end else begin
          x     <= xn;
          count <= count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      res_root   <= x;
      res_count  <= count;
      res_status <= fin_status;
    end
  end

  assign result.valid           = res_valid;
  assign result.root            = res_root;
  assign result.iteration_count = res_count;
  assign result.status          = res_status;

  `QRC_ASSERT_IMPLY(a_div_start_idle, clk, rst, div_start, !div_stat.busy)
  `QRC_ASSERT_NEXT(a_div_wait, clk, rst, (state == S_DIV_Q) && !div_stat.done, state == S_DIV_Q)
  `QRC_ASSERT_IMPLY(a_zero_deriv, clk, rst, fin_load && (fin_status == ST_ZERO_DERIV), f1 == '0)

endmodule

// ----- hdl/qrc_mul.sv -----
`timescale 1ns / 1ps
// Shared 32x32 signed multiplier with a registered 64-bit product.
// Depends on qrc_pkg for widths.
module qrc_mul (
  input  logic                                clk,
  input  logic signed [qrc_pkg::WORD_W-1:0]   op_a,
  input  logic signed [qrc_pkg::WORD_W-1:0]   op_b,
  output logic signed [qrc_pkg::PROD_W-1:0]   prod
);
  import qrc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

// ----- hdl/qrc_div.sv -----
`timescale 1ns / 1ps
// Shared radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on qrc_pkg; the quotient comes out saturated to 32 signed bits.
module qrc_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [qrc_pkg::PROD_W-1:0]    dividend,
  input  logic signed [qrc_pkg::DIVISOR_W-1:0] divisor,
  output qrc_pkg::div_status_t                 stat,
  output logic signed [qrc_pkg::WORD_W-1:0]    quotient
);
  import qrc_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic                    busy;
  logic                    done;
  logic [STEP_W-1:0]       step;
  logic [DIVISOR_W-1:0]    rem;
  logic [PROD_W-1:0]       quo;
  logic [DIVISOR_W-1:0]    dmag;
  logic                    neg;

  logic [PROD_W-1:0]       dvd_mag;
  logic [DIVISOR_W-1:0]    dvs_mag;
  logic [DIVISOR_W:0]      trial;
  logic [DIVISOR_W:0]      diff;
  logic                    fits;
  logic                    over_pos;
  logic                    over_neg;

  assign dvd_mag = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
  assign dvs_mag = divisor[DIVISOR_W-1] ? DIVISOR_W'(-divisor) : DIVISOR_W'(divisor);

  assign trial = {rem, quo[PROD_W-1]};
  assign fits  = trial >= {1'b0, dmag};
  assign diff  = trial - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dvd_mag;
      rem  <= '0;
      dmag <= dvs_mag;
      neg  <= dividend[PROD_W-1] ^ divisor[DIVISOR_W-1];
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

  // The magnitude may exceed the 32-bit range; clamp by sign.
  assign over_pos = |quo[PROD_W-1:WORD_W-1];
  assign over_neg = (|quo[PROD_W-1:WORD_W]) | (quo[WORD_W-1] & (|quo[WORD_W-2:0]));

  always_comb begin
    if (neg) begin
      quotient = over_neg ? S32_MIN : WORD_W'(32'd0 - quo[WORD_W-1:0]);
    end else begin
      quotient = over_pos ? S32_MAX : quo[WORD_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_root_chebyshev_top: sends root-finding jobs and
// register writes, and checks every result against a hand-worked value or a local
// fixed-point Chebyshev solver. Depends on qrc_pkg, the channel interfaces in qrc_ifs and the block's RTL.
module tb_top;
  import qrc_pkg::*;

  localparam int FB = FRACTION_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = REG_MAX_ITER + 8'd1;
  localparam int PROBE_ROWS = 20;
  localparam int PHASES = 6;
  localparam int JOBS_PER_PHASE = 272;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [WORD_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [WORD_W-1:0] Q_TWO = 32'sh0002_0000;
  localparam logic signed [WORD_W-1:0] Q_THREE = 32'sh0003_0000;
  localparam logic signed [WORD_W-1:0] Q_FOUR = 32'sh0004_0000;
  localparam logic signed [WORD_W-1:0] Q_FIVE = 32'sh0005_0000;
  localparam logic signed [WORD_W-1:0] Q_NEG_ONE = 32'shFFFF_0000;
  localparam logic signed [WORD_W-1:0] Q_NEG_TWO = 32'shFFFE_0000;
  localparam logic signed [WORD_W-1:0] Q_NEG_THREE = 32'shFFFD_0000;
  localparam logic signed [WORD_W-1:0] Q_NEG_FOUR = 32'shFFFC_0000;
  localparam logic signed [WORD_W-1:0] Q_NEG_SIXTEEN = 32'shFFF0_0000;

  typedef struct packed {
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic signed [WORD_W-1:0] c;
    logic signed [WORD_W-1:0] x;
  } job_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] root;
    logic [ITER_W-1:0]        count;
    status_t                  status;
  } root_result_t;

  typedef struct packed {
    job_t                  job;
    logic [CFG_DATA_W-1:0] tol_word;
    logic [CFG_DATA_W-1:0] lim_word;
    logic                  typed;
    root_result_t          want;
  } probe_t;

  localparam root_result_t UNTYPED = '{32'sd0, 8'd0, ST_CONVERGED};

  // Directed jobs. Rows that carry a typed result can be worked out by hand; the rest
  // go through the solver below. Register values change between groups of rows.
  localparam probe_t PROBES [PROBE_ROWS] = '{
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 32'd7, 32'd64, 1'b1, '{32'sd0, 8'd0, ST_CONVERGED}},
    '{'{32'sd0, 32'sd0, 32'sd6, 32'sd0}, 32'd7, 32'd64, 1'b1, '{32'sd0, 8'd0, ST_CONVERGED}},
    '{'{32'sd0, 32'sd0, 32'sd7, 32'sd0}, 32'd7, 32'd64, 1'b1, '{32'sd0, 8'd0, ST_ZERO_DERIV}},
    '{'{32'sd0, 32'sd0, -32'sd7, 32'sd0}, 32'd7, 32'd64, 1'b1, '{32'sd0, 8'd0, ST_ZERO_DERIV}},
    '{'{Q_ONE, 32'sd0, Q_NEG_FOUR, Q_TWO}, 32'd7, 32'd64, 1'b1, '{Q_TWO, 8'd0, ST_CONVERGED}},
    '{'{S32_MIN, S32_MIN, S32_MIN, S32_MIN}, 32'd7, 32'd64, 1'b0, UNTYPED},
    '{'{S32_MAX, S32_MAX, S32_MAX, S32_MAX}, 32'd7, 32'd64, 1'b0, UNTYPED},
    '{'{Q_ONE, 32'sd0, Q_NEG_FOUR, Q_THREE}, 32'd7, 32'd64, 1'b0, UNTYPED},
    '{'{Q_ONE, 32'sd0, Q_FOUR, Q_ONE}, 32'd7, 32'd64, 1'b0, UNTYPED},
    '{'{32'sd0, Q_TWO, Q_NEG_THREE, 32'sd0}, 32'd7, 32'd64, 1'b0, UNTYPED},
    '{'{Q_NEG_ONE, Q_THREE, 32'sd0, Q_FIVE}, 32'd7, 32'd64, 1'b0, UNTYPED},
    '{'{S32_MAX, S32_MIN, 32'sd0, Q_ONE}, 32'd7, 32'd64, 1'b0, UNTYPED},
    '{'{Q_ONE, 32'sd0, Q_NEG_FOUR, Q_TWO}, 32'd0, 32'd255, 1'b1, '{Q_TWO, 8'd0, ST_UNCHANGED}},
    '{'{Q_ONE, 32'sd0, Q_NEG_TWO, Q_ONE}, 32'd0, 32'd255, 1'b0, UNTYPED},
    '{'{32'sd0, 32'sd0, 32'sd0, Q_FIVE}, 32'd0, 32'd255, 1'b1, '{Q_FIVE, 8'd0, ST_ZERO_DERIV}},
    '{'{32'sd0, 32'sd0, 32'sd65535, 32'sd0}, 32'd65536, 32'd1, 1'b1,
      '{32'sd0, 8'd0, ST_CONVERGED}},
    '{'{32'sd0, 32'sd0, 32'sd65536, 32'sd0}, 32'd65536, 32'd1, 1'b1,
      '{32'sd0, 8'd0, ST_ZERO_DERIV}},
    '{'{Q_ONE, 32'sd0, Q_NEG_SIXTEEN, Q_ONE}, 32'd65536, 32'd1, 1'b0, UNTYPED},
    // Upper register bits are dropped: tolerance becomes 131071 and the step limit zero.
    '{'{32'sd0, 32'sd0, 32'sd200000, 32'sd0}, 32'hFFFF_FFFF, 32'hABCD_FF00, 1'b1,
      '{32'sd0, 8'd0, ST_LIMIT}},
    '{'{32'sd0, 32'sd0, 32'sd131070, 32'sd0}, 32'hFFFF_FFFF, 32'hABCD_FF00, 1'b1,
      '{32'sd0, 8'd0, ST_CONVERGED}}
  };

  localparam logic [CFG_DATA_W-1:0] PHASE_TOL [PHASES] = '{32'd7, 32'd0, 32'd65536, 32'd300,
                                                           32'd1, 32'd20};
  localparam logic [CFG_DATA_W-1:0] PHASE_LIM [PHASES] = '{32'd8, 32'd6, 32'd12, 32'd4,
                                                           32'd1, 32'd10};

  logic clk;
  logic rst;

  qrc_job_if    job_bus();
  qrc_result_if result_bus();
  qrc_cfg_if    cfg_bus();

  quadratic_root_chebyshev_top dut (
    .clk    (clk),
    .rst    (rst),
    .job    (job_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  root_result_t     pending_roots [$];
  root_result_t     wanted;
  logic [TOL_W-1:0]  tol_q = TOL_RESET;
  logic [ITER_W-1:0] lim_q = MAX_ITER_RESET;
  int     send_idle_pct = 20;
  int     stall_pct = 47;
  int     failures = 0;
  int     reported = 0;
  int     jobs_sent = 0;
  int     results_checked = 0;
  int     settings_used = 1;
  int     status_seen [4] = '{0, 0, 0, 0};
  longint cycles = 0;
  longint cycle_budget = 50000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_word(longint v);
    if (v > S32_MAX_W) return S32_MAX_W;
    if (v < S32_MIN_W) return S32_MIN_W;
    return v;
  endfunction

  // Runs one job to completion the way the block is meant to.
  function automatic root_result_t chebyshev_solve(job_t j, logic [TOL_W-1:0] tol,
                                                   logic [ITER_W-1:0] lim);
    longint a, b, c, x, ax, axx, bx, f, f1, f2, mag, q, q2, t, xn;
    int unsigned steps;
    root_result_t r;
    a = j.a;
    b = j.b;
    c = j.c;
    x = j.x;
    steps = 0;
    forever begin
      ax = clamp_word((a * x) >>> FB);
      axx = clamp_word((ax * x) >>> FB);
      bx = clamp_word((b * x) >>> FB);
      f = clamp_word(axx + bx + c);
      f1 = clamp_word(2 * ax + b);
      f2 = clamp_word(2 * a);
      mag = (f < 0) ? -f : f;
      if (mag < longint'(tol)) begin
        r.status = ST_CONVERGED;
        break;
      end
      if (steps >= lim) begin
        r.status = ST_LIMIT;
        break;
      end
      if (f1 == 0) begin
        r.status = ST_ZERO_DERIV;
        break;
      end
      q = clamp_word((f * ONE) / f1);
      q2 = clamp_word((q * q) >>> FB);
      t = clamp_word((q2 * f2) / (2 * f1));
      xn = clamp_word(x - q - t);
      if (xn == x) begin
        r.status = ST_UNCHANGED;
        break;
      end
      x = xn;
      steps++;
    end
    r.root = x[WORD_W-1:0];
    r.count = steps[ITER_W-1:0];
    return r;
  endfunction

  function automatic longint rand_fixed(int bits);
    longint mag;
    mag = longint'($urandom_range((1 << bits) - 1));
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // Mostly quadratics built from two known roots with a guess near one of them, so the
  // iteration gets to converge; the rest are raw words, rootless, linear or far guesses.
  function automatic job_t make_job();
    longint r1, r2, a, b, c, x;
    int kind;
    job_t j;
    kind = $urandom_range(99);
    a = rand_fixed($urandom_range(10, 19));
    if (a == 0) a = ONE;
    r1 = rand_fixed($urandom_range(8, 22));
    r2 = rand_fixed($urandom_range(8, 22));
    b = -((a * (r1 + r2)) >>> FB);
    c = (((a * r1) >>> FB) * r2) >>> FB;
    x = r1 + rand_fixed($urandom_range(6, 18));
    if (kind >= 70 && kind < 80) begin
      a = $signed($urandom);
      b = $signed($urandom);
      c = $signed($urandom);
      x = $signed($urandom);
    end else if (kind >= 80 && kind < 88) begin
      b = rand_fixed(12);
      c = ((r1 < 0) ? -r1 : r1) + ONE;
      if (a < 0) c = -c;
    end else if (kind >= 88 && kind < 94) begin
      a = 0;
    end else if (kind >= 94) begin
      x = $signed($urandom);
    end
    j.a = clamp_word(a);
    j.b = clamp_word(b);
    j.c = clamp_word(c);
    j.x = clamp_word(x);
    return j;
  endfunction

  task automatic send_job(job_t j, logic typed, root_result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      job_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    job_bus.valid <= 1'b1;
    job_bus.coefficient_a <= j.a;
    job_bus.coefficient_b <= j.b;
    job_bus.coefficient_c <= j.c;
    job_bus.first_guess <= j.x;
    do @(posedge clk); while (!job_bus.ready);
    pending_roots.push_back(typed ? want : chebyshev_solve(j, tol_q, lim_q));
    jobs_sent++;
    cycle_budget += (longint'(lim_q) + 1) * 500 + 300;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == REG_TOLERANCE) tol_q = data[TOL_W-1:0];
    else if (idx == REG_MAX_ITER) lim_q = data[ITER_W-1:0];
  endtask

  task automatic apply_settings(logic [CFG_DATA_W-1:0] tol_word,
                                logic [CFG_DATA_W-1:0] lim_word);
    write_reg(REG_TOLERANCE, tol_word);
    write_reg(REG_MAX_ITER, lim_word);
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  // Holds off new jobs until every result is back, then lets the block settle.
  task automatic quiesce();
    job_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_roots.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_roots.size() == 0) begin
        failures++;
        if (reported < REPORT_LIMIT)
          $display("Unexpected result beat: root %0d count %0d status %0d",
                   result_bus.root, result_bus.iteration_count, result_bus.status);
        reported++;
      end else begin
        wanted = pending_roots.pop_front();
        results_checked++;
        status_seen[result_bus.status]++;
        if (result_bus.root !== wanted.root || result_bus.iteration_count !== wanted.count ||
            result_bus.status !== wanted.status) begin
          failures++;
          if (reported < REPORT_LIMIT)
            $display("Mismatch on result %0d: expected root %0d count %0d status %0d, %s",
                     results_checked, wanted.root, wanted.count, wanted.status,
                     $sformatf("got root %0d count %0d status %0d", result_bus.root,
                               result_bus.iteration_count, result_bus.status));
          reported++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_budget) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               pending_roots.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    job_bus.valid <= 1'b0;
    job_bus.coefficient_a <= '0;
    job_bus.coefficient_b <= '0;
    job_bus.coefficient_c <= '0;
    job_bus.first_guess <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A write past the register list must leave both registers alone.
    write_reg(REG_NONE, '1);
    cfg_bus.valid <= 1'b0;

    for (int i = 0; i < PROBE_ROWS; i++) begin
      if (PROBES[i].tol_word[TOL_W-1:0] != tol_q ||
          PROBES[i].lim_word[ITER_W-1:0] != lim_q) begin
        quiesce();
        apply_settings(PROBES[i].tol_word, PROBES[i].lim_word);
      end
      send_job(PROBES[i].job, PROBES[i].typed, PROBES[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      apply_settings(PHASE_TOL[p], PHASE_LIM[p]);
      case (p / 2)
        0: begin
          send_idle_pct = 20;
          stall_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          stall_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      repeat (JOBS_PER_PHASE) send_job(make_job(), 1'b0, UNTYPED);
    end

    quiesce();
    repeat (200) @(posedge clk);
    if (pending_roots.size() != 0) begin
      failures += pending_roots.size();
      $display("%0d expected results never arrived", pending_roots.size());
    end

    $display("Sent %0d jobs under %0d register settings; %0d results checked, %0d failures.",
             jobs_sent, settings_used, results_checked, failures);
    $display("Endings seen: converged %0d, unchanged %0d, zero derivative %0d, limit %0d.",
             status_seen[ST_CONVERGED], status_seen[ST_UNCHANGED],
             status_seen[ST_ZERO_DERIV], status_seen[ST_LIMIT]);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/qrc_pkg.sv
hdl/qrc_ifs.sv
hdl/qrc_mul.sv
hdl/qrc_div.sv
hdl/quadratic_root_chebyshev_top.sv
tb/sv/tb_top.sv
